/* src/iss_pkg.sv */
// Shared types, codes and sizes for the indexed sequence store.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package iss_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int CMP_W      = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_APPEND = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_DONE
  } iss_state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  index;
    logic [31:0] value;
  } iss_in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  count;
  } iss_out_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } iss_mem_ctrl_t;

endpackage

`default_nettype wire

/* src/iss_mem.sv */
// Word store of the sequence: one write port and one registered read port.
// Depends on iss_pkg for sizes and the control struct.
`default_nettype none

module iss_mem
  import iss_pkg::*;
(
  input  wire logic                  clk,
  input  wire iss_mem_ctrl_t         ctrl,
  output logic [DATA_WIDTH-1:0]      rdata
);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctrl.we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    rdata_r <= mem[ctrl.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/iss_seq.sv */
// Sequencer of the store: decodes a request, checks it against the count and
// moves words one place per cycle through the memory port. Depends on iss_pkg.
`default_nettype none

module iss_seq
  import iss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire iss_in_t               req,
  input  wire logic [DATA_WIDTH-1:0] rdata,
  output logic                       busy,
  output iss_mem_ctrl_t              ctrl,
  output logic                       res_valid,
  output iss_out_t                   res
);

  iss_state_t        state_r, state_nxt;
  logic [2:0]        req_r;
  logic [4:0]        pos_r;
  logic [31:0]       value_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  tgt_r, tgt_nxt;
  logic [31:0]       rd_r, rd_nxt;
  logic [1:0]        sts_r, sts_nxt;

  logic              accept;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              range_rd, range_ins, full;
  logic [CNT_W-1:0]  tgt;
  logic              at_tgt, rm_last, up_last, dn_last;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    pos_ext   = CMP_W'(pos_r);
    cnt_ext   = CMP_W'(count_r);
    range_rd  = (pos_ext >= cnt_ext);
    range_ins = (pos_ext > cnt_ext);
    full      = (count_r == CNT_W'(CAPACITY));
    tgt       = (req_r == REQ_APPEND) ? count_r : CNT_W'(pos_r);
    at_tgt    = (count_r == tgt);
    rm_last   = (({1'b0, tgt} + (CNT_W + 1)'(1)) == {1'b0, count_r});
    up_last   = ((ptr_r - CNT_W'(1)) == tgt_r);
    dn_last   = (({1'b0, ptr_r} + (CNT_W + 1)'(2)) == {1'b0, count_r});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (req_r)
          REQ_READ:   state_nxt = range_rd ? S_DONE : S_READ;
          REQ_INSERT: begin
            if (range_ins || full) state_nxt = S_DONE;
            else state_nxt = at_tgt ? S_PUT : S_SHIFT_UP;
          end
          REQ_APPEND: state_nxt = full ? S_DONE : S_PUT;
          REQ_REMOVE: begin
            if (range_rd || rm_last) state_nxt = S_DONE;
            else state_nxt = S_SHIFT_DN;
          end
          default:    state_nxt = S_DONE;
        endcase
      end
      S_READ:     state_nxt = S_DONE;
      S_SHIFT_UP: state_nxt = up_last ? S_PUT : S_SHIFT_UP;
      S_SHIFT_DN: state_nxt = dn_last ? S_DONE : S_SHIFT_DN;
      S_PUT:      state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    tgt_nxt    = tgt_r;
    rd_nxt     = rd_r;
    sts_nxt    = sts_r;
    res_valid  = 1'b0;
    res        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rd_nxt  = '0;
          sts_nxt = STS_OK;
        end
      end
      S_DECODE: begin
        tgt_nxt = tgt;
        case (req_r)
          REQ_READ: begin
            if (range_rd) sts_nxt = STS_RANGE;
            ctrl.raddr = tgt[IDX_W-1:0];
          end
          REQ_INSERT, REQ_APPEND: begin
            if ((req_r == REQ_INSERT) && range_ins) begin
              sts_nxt = STS_RANGE;
            end else if (full) begin
              sts_nxt = STS_FULL;
            end else begin
              ptr_nxt    = count_r;
              ctrl.raddr = IDX_W'(count_r - CNT_W'(1));
            end
          end
          REQ_REMOVE: begin
            if (range_rd) begin
              sts_nxt = STS_RANGE;
            end else begin
              ptr_nxt    = tgt;
              ctrl.raddr = IDX_W'(tgt + CNT_W'(1));
              if (rm_last) count_nxt = count_r - CNT_W'(1);
            end
          end
          REQ_CLEAR: count_nxt = '0;
          default: ;
        endcase
      end
      S_READ: rd_nxt = 32'(rdata);
      S_SHIFT_UP: begin
        ctrl.we    = 1'b1;
        ctrl.waddr = ptr_r[IDX_W-1:0];
        ctrl.wdata = rdata;
        ctrl.raddr = IDX_W'(ptr_r - CNT_W'(2));
        ptr_nxt    = ptr_r - CNT_W'(1);
      end
      S_SHIFT_DN: begin
        ctrl.we    = 1'b1;
        ctrl.waddr = ptr_r[IDX_W-1:0];
        ctrl.wdata = rdata;
        ctrl.raddr = IDX_W'(ptr_r + CNT_W'(2));
        ptr_nxt    = ptr_r + CNT_W'(1);
        if (dn_last) count_nxt = count_r - CNT_W'(1);
      end
      S_PUT: begin
        ctrl.we    = 1'b1;
        ctrl.waddr = tgt_r[IDX_W-1:0];
        ctrl.wdata = DATA_WIDTH'(value_r);
        count_nxt  = count_r + CNT_W'(1);
      end
      S_DONE: begin
        res_valid      = 1'b1;
        res.read_value = rd_r;
        res.status     = sts_r;
        res.count      = 5'(count_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= req.req_type;
      pos_r   <= req.index;
      value_r <= req.value;
    end
    ptr_r <= ptr_nxt;
    tgt_r <= tgt_nxt;
    rd_r  <= rd_nxt;
    sts_r <= sts_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.we |-> (state_r == S_SHIFT_UP || state_r == S_SHIFT_DN || state_r == S_PUT))
    else $error("memory written outside a move or put step");

  a_up_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_UP) |-> (ptr_r > tgt_r))
    else $error("upward shift ran past the insert position");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (state_r == S_IDLE))
    else $error("result step did not return to idle");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DECODE))
    else $error("accepted request not decoded");

endmodule

`default_nettype wire

/* src/indexed_sequence_store.sv */
// Top level of the indexed sequence store: sequencer, word memory and the
// result register. Depends on iss_pkg, iss_seq and iss_mem.
//
// A request is transferred when start is high and busy is low; busy stays
// high until the request is finished. Each word move is its own step on the
// memory port, so an insert, or a remove of a word other than the last,
// takes longer the further its index lies below the count. The result
// appears on out_data for exactly one cycle with out_valid high, in the
// first cycle in which busy is low again, so the next request can be
// transferred in that same cycle; the receiver cannot stall it. Only the
// low DATA_WIDTH bits of a value are stored.
`default_nettype none

module indexed_sequence_store
  import iss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire iss_in_t  in_data,
  output logic          busy,
  output logic          out_valid,
  output iss_out_t      out_data
);

  iss_mem_ctrl_t         ctrl;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  res_valid;
  iss_out_t              res;
  logic                  out_valid_r;
  iss_out_t              out_data_r;

  iss_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (in_data),
    .rdata     (rdata),
    .busy      (busy),
    .ctrl      (ctrl),
    .res_valid (res_valid),
    .res       (res)
  );

  iss_mem u_mem (
    .clk   (clk),
    .ctrl  (ctrl),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* test/indexed_sequence_store_tb.sv */
// Self-checking testbench for indexed_sequence_store: directed edge cases and
// random request traffic, each result compared against an in-bench predictor.
// Depends on iss_pkg and the indexed_sequence_store RTL.
`timescale 1ns / 100ps

module indexed_sequence_store_tb
  import iss_pkg::*;
();

  localparam logic [2:0] REQ_SPARE_LO   = 3'd5;
  localparam logic [2:0] REQ_SPARE_MID  = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI   = 3'd7;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         MAX_REPORTS    = 50;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  iss_in_t  in_data;
  logic     busy;
  logic     out_valid;
  iss_out_t out_data;

  logic [DATA_WIDTH-1:0] seq_words [CAPACITY];
  int unsigned           seq_len;
  iss_out_t              expected_results [$];

  int unsigned gap_pct;
  bit          grow_trend;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned range_errors;
  int unsigned full_errors;
  int unsigned mismatches;

  indexed_sequence_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic iss_in_t mk_req(input logic [2:0] kind, input logic [4:0] idx,
                                     input logic [31:0] word);
    iss_in_t r;
    r.req_type = kind;
    r.index    = idx;
    r.value    = word;
    return r;
  endfunction

  // Applies one request to the predicted sequence and returns the response it should give.
  function automatic iss_out_t apply_request(input iss_in_t req);
    iss_out_t    rsp;
    int unsigned pos;
    int unsigned k;
    rsp.read_value = '0;
    rsp.status     = STS_OK;
    pos            = 32'(req.index);
    case (req.req_type)
      REQ_READ: begin
        if (pos >= seq_len) rsp.status = STS_RANGE;
        else rsp.read_value = 32'(seq_words[pos]);
      end
      REQ_INSERT, REQ_APPEND: begin
        if (req.req_type == REQ_APPEND) pos = seq_len;
        if (pos > seq_len) begin
          rsp.status = STS_RANGE;
        end else if (seq_len >= CAPACITY) begin
          rsp.status = STS_FULL;
        end else begin
          for (k = seq_len; k > pos; k--) seq_words[k] = seq_words[k-1];
          seq_words[pos] = req.value[DATA_WIDTH-1:0];
          seq_len++;
        end
      end
      REQ_REMOVE: begin
        if (pos >= seq_len) begin
          rsp.status = STS_RANGE;
        end else begin
          for (k = pos; k + 1 < seq_len; k++) seq_words[k] = seq_words[k+1];
          seq_len--;
        end
      end
      REQ_CLEAR: seq_len = 0;
      default: ;
    endcase
    if (rsp.status == STS_RANGE) range_errors++;
    if (rsp.status == STS_FULL) full_errors++;
    rsp.count = 5'(seq_len);
    return rsp;
  endfunction

  task automatic send_request(input iss_in_t req);
    iss_out_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    predicted        = apply_request(req);
    expected_results = {expected_results, predicted};
    requests_sent++;
  endtask

  always @(posedge clk) begin
    iss_out_t exp_rsp;
    if (rst_n && out_valid) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected, got %h", $time, out_data);
      end else begin
        exp_rsp = expected_results.pop_front();
        if (out_data.read_value !== exp_rsp.read_value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: read_value expected %h, actual %h", $time,
                     exp_rsp.read_value, out_data.read_value);
        end
        if (out_data.status !== exp_rsp.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: status expected %0d, actual %0d", $time,
                     exp_rsp.status, out_data.status);
        end
        if (out_data.count !== exp_rsp.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: count expected %0d, actual %0d", $time,
                     exp_rsp.count, out_data.count);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // Random request mix; a slowly flipping trend drives the store between empty and full.
  function automatic iss_in_t make_request();
    iss_in_t     r;
    int unsigned pick;
    pick       = $urandom_range(99);
    r.req_type = REQ_READ;
    r.index    = 5'($urandom_range(31));
    case ($urandom_range(9))
      0:       r.value = 32'hFFFF_FFFF;
      1:       r.value = 32'h0;
      default: r.value = $urandom();
    endcase
    if (pick < 22) begin
      r.req_type = REQ_READ;
      r.index    = (seq_len == 0) ? 5'd0 : 5'($urandom_range(seq_len - 1));
    end else if (pick < (grow_trend ? 62 : 42)) begin
      if ($urandom_range(1) == 0) begin
        r.req_type = REQ_INSERT;
        r.index    = 5'($urandom_range(seq_len));
      end else begin
        r.req_type = REQ_APPEND;
      end
    end else if (pick < 84) begin
      r.req_type = REQ_REMOVE;
      r.index    = (seq_len == 0) ? 5'd0 : 5'($urandom_range(seq_len - 1));
    end else if (pick < 91) begin
      case ($urandom_range(2))
        0:       r.req_type = REQ_READ;
        1:       r.req_type = REQ_INSERT;
        default: r.req_type = REQ_REMOVE;
      endcase
      r.index = 5'($urandom_range(31, seq_len + ((r.req_type == REQ_INSERT) ? 1 : 0)));
    end else if (pick < 93) begin
      r.req_type = REQ_CLEAR;
    end else if (pick < 96) begin
      r.req_type = 3'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO));
    end else begin
      r.req_type = 3'($urandom_range(7));
    end
    return r;
  endfunction

  task automatic test_empty_store();
    gap_pct = 30;
    send_request(mk_req(REQ_READ, 5'd0, 32'h0));
    send_request(mk_req(REQ_REMOVE, 5'd0, 32'h0));
    send_request(mk_req(REQ_INSERT, 5'd1, 32'hDEAD_BEEF));
    send_request(mk_req(REQ_SPARE_MID, 5'd31, 32'hFFFF_FFFF));
  endtask

  task automatic test_fill_and_full();
    int n;
    gap_pct = 30;
    send_request(mk_req(REQ_INSERT, 5'd0, 32'h0));
    send_request(mk_req(REQ_APPEND, 5'd0, 32'hFFFF_FFFF));
    for (n = 2; n < CAPACITY; n++) begin
      if (n % 2 == 0) send_request(mk_req(REQ_INSERT, 5'(n / 2), $urandom()));
      else send_request(mk_req(REQ_APPEND, 5'($urandom_range(31)), $urandom()));
    end
    send_request(mk_req(REQ_APPEND, 5'd0, 32'h1234_5678));
    send_request(mk_req(REQ_INSERT, 5'(CAPACITY), 32'h1234_5678));
    send_request(mk_req(REQ_INSERT, 5'(CAPACITY + 1), 32'h1234_5678));
    send_request(mk_req(REQ_READ, 5'd31, 32'h0));
    send_request(mk_req(REQ_READ, 5'(CAPACITY - 1), 32'h0));
    send_request(mk_req(REQ_REMOVE, 5'(CAPACITY - 1), 32'h0));
    send_request(mk_req(REQ_REMOVE, 5'd0, 32'h0));
    send_request(mk_req(REQ_REMOVE, 5'd7, 32'h0));
    send_request(mk_req(REQ_SPARE_LO, 5'd3, 32'hA5A5_A5A5));
    send_request(mk_req(REQ_SPARE_HI, 5'd16, 32'h5A5A_5A5A));
    send_request(mk_req(REQ_CLEAR, 5'd0, 32'h0));
    send_request(mk_req(REQ_READ, 5'd0, 32'h0));
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned n_reqs);
    int unsigned n;
    gap_pct = idle_pct;
    for (n = 0; n < n_reqs; n++) begin
      if ($urandom_range(24) == 0) grow_trend = !grow_trend;
      send_request(make_request());
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_data         = '0;
    seq_len         = 0;
    grow_trend      = 1'b1;
    requests_sent   = 0;
    results_checked = 0;
    range_errors    = 0;
    full_errors     = 0;
    mismatches      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_fill_and_full();
    test_random_traffic(30, 250);
    test_random_traffic(57, 250);
    test_random_traffic(0, 250);

    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results, with sender gaps of 30, 57 and 0 %%.",
             requests_sent, results_checked);
    $display("Predicted %0d out-of-range and %0d store-full responses; %0d mismatches.",
             range_errors, full_errors, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/iss_pkg.sv
src/iss_mem.sv
src/iss_seq.sv
src/indexed_sequence_store.sv
test/indexed_sequence_store_tb.sv
